// File: rtl/core/cdtm_pkg.sv
package cdtm_pkg;

  // Default sizes of the stores
  localparam int TraceDepth  = 64;
  localparam int ShadowDepth = 16;
  localparam int BreakSlots  = 8;
  localparam int IgnoreSlots = 8;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  // Item modes
  localparam logic [1:0] MODE_OBSERVE    = 2'd0;
  localparam logic [1:0] MODE_TOGGLE_BRK = 2'd1;
  localparam logic [1:0] MODE_TOGGLE_IGN = 2'd2;
  localparam logic [1:0] MODE_READ_TRACE = 2'd3;

  // Configuration register addresses
  localparam logic [2:0] ADDR_CHECK_STACK = 3'd0;

  // Stack range limits
  localparam logic [15:0] SP_HRAM_TOP = 16'hFF80;
  localparam logic [15:0] SP_ECHO_LOW = 16'hE000;
  localparam logic [15:0] SP_WRAM_LOW = 16'hC000;

  // Opcodes
  localparam logic [7:0] OP_SRC_BRK  = 8'h40;
  localparam logic [7:0] RST_MASK    = 8'hC7;
  localparam logic [7:0] OP_RET      = 8'hC9;
  localparam logic [7:0] OP_RETI     = 8'hD9;
  localparam logic [7:0] OP_JP       = 8'hC3;
  localparam logic [7:0] OP_JR       = 8'h18;
  localparam logic [7:0] OP_JP_HL    = 8'hE9;
  localparam logic [7:0] OP_JP_NZ    = 8'hC2;
  localparam logic [7:0] OP_RET_NZ   = 8'hC0;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;
  localparam logic [7:0] OP_RET_Z    = 8'hC8;
  localparam logic [7:0] OP_JP_Z     = 8'hCA;
  localparam logic [7:0] OP_JR_Z     = 8'h28;
  localparam logic [7:0] OP_RET_NC   = 8'hD0;
  localparam logic [7:0] OP_JP_NC    = 8'hD2;
  localparam logic [7:0] OP_JR_NC    = 8'h30;
  localparam logic [7:0] OP_JR_C     = 8'h38;
  localparam logic [7:0] OP_RET_C    = 8'hD8;
  localparam logic [7:0] OP_JP_C     = 8'hDA;
  localparam logic [7:0] OP_CALL     = 8'hCD;
  localparam logic [7:0] OP_CALL_NZ  = 8'hC4;
  localparam logic [7:0] OP_CALL_Z   = 8'hCC;
  localparam logic [7:0] OP_CALL_NC  = 8'hD4;
  localparam logic [7:0] OP_CALL_C   = 8'hDC;

  // Classified word passed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] sp_push;
    logic [15:0] address;
    logic [5:0]  trace_index;
    logic        chk;
    logic        taken;
    logic        ret;
    logic        call;
    logic        src_op;
    logic        range_bad;
  } item_t;

  // Result flags of one word
  typedef struct packed {
    logic stop;
    logic breakpoint_hit;
    logic source_break;
    logic stack_range_bad;
    logic return_mismatch;
    logic return_empty;
    logic shadow_overflow;
    logic jump_logged;
    logic now_present;
    logic table_full;
  } flags_t;

  function automatic logic is_rst(input logic [7:0] op);
    return (op & RST_MASK) == RST_MASK;
  endfunction

  function automatic logic is_taken(input logic [7:0] op, input logic z, input logic c);
    return is_rst(op) || op == OP_RET || op == OP_RETI || op == OP_JP ||
           op == OP_JR || op == OP_JP_HL ||
           (!z && (op == OP_JP_NZ || op == OP_RET_NZ || op == OP_JR_NZ)) ||
           (z && (op == OP_RET_Z || op == OP_JP_Z || op == OP_JR_Z)) ||
           (!c && (op == OP_RET_NC || op == OP_JP_NC || op == OP_JR_NC)) ||
           (c && (op == OP_JR_C || op == OP_RET_C || op == OP_JP_C));
  endfunction

  function automatic logic is_ret(input logic [7:0] op, input logic z, input logic c);
    return is_rst(op) || op == OP_RET ||
           (!z && op == OP_RET_NZ) || (z && op == OP_RET_Z) ||
           (!c && op == OP_RET_NC) || (c && op == OP_RET_C);
  endfunction

  function automatic logic is_call(input logic [7:0] op, input logic z, input logic c);
    return op == OP_CALL || (!z && op == OP_CALL_NZ) || (z && op == OP_CALL_Z) ||
           (!c && op == OP_CALL_NC) || (c && op == OP_CALL_C);
  endfunction

endpackage

// File: rtl/core/cpu_debug_trace_monitor.sv
// Debug monitor for the retired-instruction stream of an 8-bit CPU.
// Input words arrive on the s_axis channel; tuser carries the mode
// (observe, toggle breakpoint, toggle ignored address, read trace) and
// tdata the instruction fields. Each input word yields exactly one result
// word on the m_axis channel, in order: the stop and check flags, the
// toggle outcome, or a jump trace entry.
// A front stage classifies the opcode and checks the sp range, a 2-word
// queue decouples it from the back stage, which owns the jump trace memory,
// the shadow stack and the breakpoint and ignore tables.
// Throughput: one word per cycle while m_axis_tready is high. Each word is
// written into the queue and then loaded into the back stage result
// register, which also holds the registered trace memory read.
// When m_axis_tready is low the result register holds, the back stage
// stops, the queue fills and s_axis_tready drops once it is full.
// Reset clears the trace (empty entries read as zero), empties the shadow
// stack and both tables, and clears check_stack; no clearing pass is run.
// The check_stack register sits at address 0 of the APB port; the user must
// write it only while no word is in flight, which the block does not enforce.
module cpu_debug_trace_monitor
  import cdtm_pkg::*;
#(
  parameter int TRACE_DEPTH  = TraceDepth,
  parameter int SHADOW_DEPTH = ShadowDepth,
  parameter int BREAK_SLOTS  = BreakSlots,
  parameter int IGNORE_SLOTS = IgnoreSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // tdata: pc[15:0], sp[31:16], opcode[39:32], flag_z[40], flag_c[41],
  //        address[57:42], trace_index[63:58]
  input  logic [63:0] s_axis_tdata,
  // Result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: stop[0], breakpoint_hit[1], source_break[2], stack_range_bad[3],
  //        return_mismatch[4], return_empty[5], shadow_overflow[6],
  //        jump_logged[7], now_present[8], table_full[9], read_pc[25:10],
  //        zero[31:26]
  output logic [31:0] m_axis_tdata,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        check_stack_q;
  logic        q_full, q_push, q_valid, q_pop;
  item_t       front_item, back_item;
  flags_t      flags;
  logic [15:0] read_pc;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CHECK_STACK) ? {31'd0, check_stack_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_stack_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CHECK_STACK) begin
      check_stack_q <= pwdata[0];
    end
  end

  cdtm_front u_front (
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_user_i      (s_axis_tuser),
    .s_data_i      (s_axis_tdata),
    .check_stack_i (check_stack_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .item_o        (front_item)
  );

  cdtm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (back_item)
  );

  cdtm_back #(
    .TRACE_DEPTH  (TRACE_DEPTH),
    .SHADOW_DEPTH (SHADOW_DEPTH),
    .BREAK_SLOTS  (BREAK_SLOTS),
    .IGNORE_SLOTS (IGNORE_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (back_item),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .flags_o      (flags),
    .read_pc_o    (read_pc)
  );

  // Pack the result word
  assign m_axis_tdata = {6'd0, read_pc,
                         flags.table_full, flags.now_present, flags.jump_logged,
                         flags.shadow_overflow, flags.return_empty,
                         flags.return_mismatch, flags.stack_range_bad,
                         flags.source_break, flags.breakpoint_hit, flags.stop};

endmodule

// File: rtl/core/cdtm_front.sv
module cdtm_front
  import cdtm_pkg::*;
(
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [1:0]  s_user_i,
  input  logic [63:0] s_data_i,
  input  logic        check_stack_i,
  input  logic        q_full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [15:0] sp;
  logic [7:0]  op;
  logic        z;
  logic        c;

  // Take a word whenever the queue has room
  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

  assign sp = s_data_i[31:16];
  assign op = s_data_i[39:32];
  assign z  = s_data_i[40];
  assign c  = s_data_i[41];

  // Unpack and classify the instruction
  always_comb begin
    item_o.mode        = s_user_i;
    item_o.pc          = s_data_i[15:0];
    item_o.sp          = sp;
    item_o.sp_push     = sp - 16'd2;
    item_o.address     = s_data_i[57:42];
    item_o.trace_index = s_data_i[63:58];
    item_o.chk         = check_stack_i;
    item_o.taken       = is_taken(op, z, c);
    item_o.ret         = is_ret(op, z, c);
    item_o.call        = is_call(op, z, c);
    item_o.src_op      = (op == OP_SRC_BRK);
    item_o.range_bad   = check_stack_i &&
                         ((sp <= SP_HRAM_TOP && sp > SP_ECHO_LOW) ||
                          (sp <= SP_WRAM_LOW && sp != 16'd0));
  end

endmodule

// File: rtl/core/cdtm_queue.sv
module cdtm_queue
  import cdtm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  item_t              slots_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q;
  logic [QueueAw-1:0] rd_ptr_q;
  logic [QueueCw-1:0] count_q;

  assign full_o  = (count_q == QueueCw'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/cdtm_back.sv
module cdtm_back
  import cdtm_pkg::*;
#(
  parameter int TRACE_DEPTH  = TraceDepth,
  parameter int SHADOW_DEPTH = ShadowDepth,
  parameter int BREAK_SLOTS  = BreakSlots,
  parameter int IGNORE_SLOTS = IgnoreSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output flags_t      flags_o,
  output logic [15:0] read_pc_o
);

  localparam int TraceAw  = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int FillW    = $clog2(TRACE_DEPTH + 1);
  localparam int SumW     = ((TraceAw > 6) ? TraceAw : 6) + 1;
  localparam int ShadowAw = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;
  localparam int ShadowCw = $clog2(SHADOW_DEPTH + 1);
  localparam int BreakAw  = (BREAK_SLOTS > 1) ? $clog2(BREAK_SLOTS) : 1;
  localparam int IgnoreAw = (IGNORE_SLOTS > 1) ? $clog2(IGNORE_SLOTS) : 1;

  // Jump trace memory with head and fill count
  logic [15:0]        trace_mem [TRACE_DEPTH];
  logic [TraceAw-1:0] head_q, head_d;
  logic [FillW-1:0]   fill_q, fill_d;

  // Shadow stack
  logic [15:0]         shadow_mem [SHADOW_DEPTH];
  logic [ShadowCw-1:0] shadow_cnt_q, shadow_cnt_d;

  // Breakpoint and ignore tables
  logic [15:0]             brk_addr_q [BREAK_SLOTS];
  logic [BREAK_SLOTS-1:0]  brk_valid_q, brk_valid_d;
  logic [15:0]             ign_addr_q [IGNORE_SLOTS];
  logic [IGNORE_SLOTS-1:0] ign_valid_q, ign_valid_d;

  // Output register
  logic        out_valid_q;
  flags_t      flags_q, flags_d;
  logic        rd_hit_q, rd_hit_d;
  logic [15:0] rd_q;

  logic                    fire;
  logic                    is_obs, is_tog_brk, is_tog_ign, is_read;
  logic                    brk_hit, ign_hit;
  logic [BREAK_SLOTS-1:0]  brk_match;
  logic                    brk_free_any;
  logic [BreakAw-1:0]      brk_free_idx;
  logic [IGNORE_SLOTS-1:0] ign_match;
  logic                    ign_free_any;
  logic [IgnoreAw-1:0]     ign_free_idx;
  logic                    brk_add, ign_add;
  logic [ShadowAw-1:0]     top_idx;
  logic [15:0]             shadow_top;
  logic                    shadow_empty, shadow_full;
  logic                    ret_pop, push_ok, log_jump;
  logic [SumW-1:0]         rd_sum, rd_wrap;
  logic [TraceAw-1:0]      rd_idx;
  logic                    tog_match, tog_free;

  assign fire  = item_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire;

  assign is_obs     = (item_i.mode == MODE_OBSERVE);
  assign is_tog_brk = (item_i.mode == MODE_TOGGLE_BRK);
  assign is_tog_ign = (item_i.mode == MODE_TOGGLE_IGN);
  assign is_read    = (item_i.mode == MODE_READ_TRACE);

  // Look up pc and the toggle address in both tables
  always_comb begin
    brk_hit      = 1'b0;
    brk_free_any = 1'b0;
    brk_free_idx = '0;
    for (int i = BREAK_SLOTS - 1; i >= 0; i--) begin
      brk_match[i] = brk_valid_q[i] && (brk_addr_q[i] == item_i.address);
      if (brk_valid_q[i] && brk_addr_q[i] == item_i.pc) begin
        brk_hit = 1'b1;
      end
      if (!brk_valid_q[i]) begin
        brk_free_any = 1'b1;
        brk_free_idx = BreakAw'(i);
      end
    end
  end

  always_comb begin
    ign_hit      = 1'b0;
    ign_free_any = 1'b0;
    ign_free_idx = '0;
    for (int i = IGNORE_SLOTS - 1; i >= 0; i--) begin
      ign_match[i] = ign_valid_q[i] && (ign_addr_q[i] == item_i.address);
      if (ign_valid_q[i] && ign_addr_q[i] == item_i.pc) begin
        ign_hit = 1'b1;
      end
      if (!ign_valid_q[i]) begin
        ign_free_any = 1'b1;
        ign_free_idx = IgnoreAw'(i);
      end
    end
  end

  // Toggle: drop a present address, else add it into the first free slot
  assign tog_match = is_tog_brk ? (|brk_match) : (|ign_match);
  assign tog_free  = is_tog_brk ? brk_free_any : ign_free_any;
  assign brk_add   = fire && is_tog_brk && !(|brk_match) && brk_free_any;
  assign ign_add   = fire && is_tog_ign && !(|ign_match) && ign_free_any;

  always_comb begin
    brk_valid_d = brk_valid_q;
    ign_valid_d = ign_valid_q;
    if (fire && is_tog_brk) begin
      brk_valid_d = brk_valid_q & ~brk_match;
    end
    if (brk_add) begin
      brk_valid_d[brk_free_idx] = 1'b1;
    end
    if (fire && is_tog_ign) begin
      ign_valid_d = ign_valid_q & ~ign_match;
    end
    if (ign_add) begin
      ign_valid_d[ign_free_idx] = 1'b1;
    end
  end

  // Shadow stack top, pop and push
  assign top_idx      = ShadowAw'(shadow_cnt_q - ShadowCw'(1));
  assign shadow_top   = shadow_mem[top_idx];
  assign shadow_empty = (shadow_cnt_q == '0);
  assign shadow_full  = (shadow_cnt_q == ShadowCw'(SHADOW_DEPTH));
  assign ret_pop      = item_i.ret && !shadow_empty && (item_i.sp == shadow_top);
  assign push_ok      = item_i.call && !shadow_full;
  assign log_jump     = fire && is_obs && item_i.taken;

  always_comb begin
    shadow_cnt_d = shadow_cnt_q;
    if (fire && is_obs && ret_pop) begin
      shadow_cnt_d = shadow_cnt_q - 1'b1;
    end else if (fire && is_obs && push_ok) begin
      shadow_cnt_d = shadow_cnt_q + 1'b1;
    end
  end

  // Advance the trace head and fill count
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (log_jump) begin
      head_d = (head_q == TraceAw'(TRACE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      if (fill_q != FillW'(TRACE_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  // Map the trace index onto the circular buffer
  assign rd_sum  = SumW'(head_q) + SumW'(item_i.trace_index);
  assign rd_wrap = (rd_sum >= SumW'(TRACE_DEPTH)) ? rd_sum - SumW'(TRACE_DEPTH) : rd_sum;
  assign rd_idx  = rd_wrap[TraceAw-1:0];
  assign rd_hit_d = is_read && (SumW'(item_i.trace_index) < SumW'(TRACE_DEPTH)) &&
                    (rd_wrap < SumW'(fill_q));

  // Build the result flags
  always_comb begin
    flags_d = '0;
    if (is_obs) begin
      flags_d.breakpoint_hit  = brk_hit;
      flags_d.source_break    = item_i.src_op && !ign_hit;
      flags_d.stack_range_bad = item_i.range_bad;
      flags_d.return_mismatch = item_i.ret && !shadow_empty && !ret_pop &&
                                !ign_hit && item_i.chk;
      flags_d.return_empty    = item_i.ret && shadow_empty && !ign_hit && item_i.chk;
      flags_d.shadow_overflow = item_i.call && shadow_full;
      flags_d.jump_logged     = item_i.taken;
      flags_d.stop            = flags_d.breakpoint_hit | flags_d.source_break |
                                flags_d.stack_range_bad | flags_d.return_mismatch |
                                flags_d.return_empty;
    end else if (is_tog_brk || is_tog_ign) begin
      flags_d.now_present = !tog_match && tog_free;
      flags_d.table_full  = !tog_match && !tog_free;
    end
  end

  // Memories and table addresses
  always_ff @(posedge clk_i) begin
    if (log_jump) begin
      trace_mem[head_q] <= item_i.pc;
    end
    if (fire) begin
      rd_q <= trace_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_obs && push_ok) begin
      shadow_mem[shadow_cnt_q[ShadowAw-1:0]] <= item_i.sp_push;
    end
    if (brk_add) begin
      brk_addr_q[brk_free_idx] <= item_i.address;
    end
    if (ign_add) begin
      ign_addr_q[ign_free_idx] <= item_i.address;
    end
    if (fire) begin
      flags_q <= flags_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      fill_q       <= '0;
      shadow_cnt_q <= '0;
      brk_valid_q  <= '0;
      ign_valid_q  <= '0;
      out_valid_q  <= 1'b0;
      rd_hit_q     <= 1'b0;
    end else begin
      head_q       <= head_d;
      fill_q       <= fill_d;
      shadow_cnt_q <= shadow_cnt_d;
      brk_valid_q  <= brk_valid_d;
      ign_valid_q  <= ign_valid_d;
      if (fire) begin
        out_valid_q <= 1'b1;
        rd_hit_q    <= rd_hit_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign flags_o     = flags_q;
  assign read_pc_o   = rd_hit_q ? rd_q : 16'd0;

endmodule
